// File: rtl/ctbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbc_pkg
// Shared types and constants of the color threshold centroid core.
// ----------------------------------------------------------------------------
package ctbc_pkg;

  localparam int PIX_W   = 8;
  localparam int FW_W    = 11;
  localparam int WSUM_W  = 28;
  localparam int XSUM_W  = 38;
  localparam int AREA_W  = 21;
  localparam int CENT_W  = 10;
  localparam int LUMA_W  = 24;
  localparam int DIV_CNT_W = 6;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;
  localparam int QDEPTH  = 2;

  // Luma weights of the nonblack test
  localparam logic [LUMA_W-1:0] LUMA_CB   = 24'd1868;
  localparam logic [LUMA_W-1:0] LUMA_CG   = 24'd9617;
  localparam logic [LUMA_W-1:0] LUMA_CR   = 24'd4899;
  localparam logic [LUMA_W-1:0] LUMA_RND  = 24'd8192;
  localparam logic [LUMA_W-1:0] LUMA_THR  = 24'd16384;

  // Register reset values
  localparam logic [PIX_W-1:0] RST_RED_MIN   = 8'd150;
  localparam logic [PIX_W-1:0] RST_RED_MAX   = 8'd255;
  localparam logic [PIX_W-1:0] RST_GREEN_MIN = 8'd0;
  localparam logic [PIX_W-1:0] RST_GREEN_MAX = 8'd120;
  localparam logic [PIX_W-1:0] RST_BLUE_MIN  = 8'd0;
  localparam logic [PIX_W-1:0] RST_BLUE_MAX  = 8'd100;
  localparam logic [FW_W-1:0]  RST_FRAME_W   = 11'd640;

  typedef enum logic [2:0] {
    REG_RED_MIN   = 3'd0,
    REG_RED_MAX   = 3'd1,
    REG_GREEN_MIN = 3'd2,
    REG_GREEN_MAX = 3'd3,
    REG_BLUE_MIN  = 3'd4,
    REG_BLUE_MAX  = 3'd5,
    REG_FRAME_W   = 3'd6
  } ctbc_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
  } ctbc_range_t;

  typedef struct packed {
    ctbc_range_t     red;
    ctbc_range_t     green;
    ctbc_range_t     blue;
    logic [FW_W-1:0] frame_width;
  } ctbc_cfg_t;

  // One classified pixel with the frame totals as they stand after it
  typedef struct packed {
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic              last;
    logic [WSUM_W-1:0] wsum;
    logic [XSUM_W-1:0] xsum;
    logic [XSUM_W-1:0] ysum;
    logic [AREA_W-1:0] area;
  } ctbc_item_t;

  typedef struct packed {
    logic              start;
    logic [XSUM_W-1:0] xsum;
    logic [XSUM_W-1:0] ysum;
    logic [WSUM_W-1:0] wsum;
  } ctbc_div_req_t;

  typedef struct packed {
    logic              busy;
    logic [CENT_W-1:0] cx;
    logic [CENT_W-1:0] cy;
  } ctbc_div_rsp_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DIV  = 1'b1
  } ctbc_bk_state_t;

  function automatic logic ctbc_nonblack(input logic [PIX_W-1:0] r,
                                         input logic [PIX_W-1:0] g,
                                         input logic [PIX_W-1:0] b);
    logic [LUMA_W-1:0] s;
    s = LUMA_CB * LUMA_W'(b) + LUMA_CG * LUMA_W'(g) + LUMA_CR * LUMA_W'(r) + LUMA_RND;
    return s >= LUMA_THR;
  endfunction

endpackage

// File: rtl/ctbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbc_front
// Thresholds each pixel, tracks raster position and accumulates moments.
// ----------------------------------------------------------------------------
module ctbc_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctbc_pkg::ctbc_cfg_t    cfg,
  input  logic                   accept,
  input  logic [ctbc_pkg::PIX_W-1:0] red,
  input  logic [ctbc_pkg::PIX_W-1:0] green,
  input  logic [ctbc_pkg::PIX_W-1:0] blue,
  input  logic                   last,
  output ctbc_pkg::ctbc_item_t   item
);
  import ctbc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  logic [CW-1:0]     col_r,  col_nxt;
  logic [RW-1:0]     row_r,  row_nxt;
  logic [WSUM_W-1:0] wsum_r, wsum_nxt;
  logic [XSUM_W-1:0] xsum_r, xsum_nxt;
  logic [XSUM_W-1:0] ysum_r, ysum_nxt;
  logic [AREA_W-1:0] area_r, area_nxt;

  logic              pass;
  logic [PIX_W-1:0]  rm, gm, bm;
  logic [CW+PIX_W-1:0] xprod;
  logic [RW+PIX_W-1:0] yprod;
  logic [WSUM_W:0]   wadd;
  logic [XSUM_W:0]   xadd, yadd;
  logic [AREA_W:0]   aadd;
  logic [WW-1:0]     fw, wlim, col_inc;

  always_comb begin
    pass = (cfg.red.lo   <= red)   && (red   <= cfg.red.hi) &&
           (cfg.green.lo <= green) && (green <= cfg.green.hi) &&
           (cfg.blue.lo  <= blue)  && (blue  <= cfg.blue.hi);
    rm = pass ? red   : '0;
    gm = pass ? green : '0;
    bm = pass ? blue  : '0;

    xprod = (CW+PIX_W)'(col_r) * (CW+PIX_W)'(rm);
    yprod = (RW+PIX_W)'(row_r) * (RW+PIX_W)'(rm);
    wadd  = {1'b0, wsum_r} + (WSUM_W+1)'(rm);
    xadd  = {1'b0, xsum_r} + (XSUM_W+1)'(xprod);
    yadd  = {1'b0, ysum_r} + (XSUM_W+1)'(yprod);
    aadd  = {1'b0, area_r} + (AREA_W+1)'(ctbc_nonblack(rm, gm, bm));

    // Saturate every accumulator at all ones
    wsum_nxt = wadd[WSUM_W] ? '1 : wadd[WSUM_W-1:0];
    xsum_nxt = xadd[XSUM_W] ? '1 : xadd[XSUM_W-1:0];
    ysum_nxt = yadd[XSUM_W] ? '1 : yadd[XSUM_W-1:0];
    area_nxt = aadd[AREA_W] ? '1 : aadd[AREA_W-1:0];

    // Clamp width into 1..MAX_WIDTH
    fw = WW'(cfg.frame_width);
    if (fw == '0) begin
      wlim = WW'(1);
    end else if (fw > WW'(MAX_WIDTH)) begin
      wlim = WW'(MAX_WIDTH);
    end else begin
      wlim = fw;
    end
    col_inc = WW'(col_r) + WW'(1);

    if (col_inc >= wlim) begin
      col_nxt = '0;
      row_nxt = (row_r == RW'(MAX_HEIGHT - 1)) ? row_r : row_r + RW'(1);
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_r;
    end

    item.red   = rm;
    item.green = gm;
    item.blue  = bm;
    item.last  = last;
    item.wsum  = wsum_nxt;
    item.xsum  = xsum_nxt;
    item.ysum  = ysum_nxt;
    item.area  = area_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      wsum_r <= '0;
      xsum_r <= '0;
      ysum_r <= '0;
      area_r <= '0;
    end else if (accept) begin
      if (last) begin
        // Clear frame state after the last pixel
        col_r  <= '0;
        row_r  <= '0;
        wsum_r <= '0;
        xsum_r <= '0;
        ysum_r <= '0;
        area_r <= '0;
      end else begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        wsum_r <= wsum_nxt;
        xsum_r <= xsum_nxt;
        ysum_r <= ysum_nxt;
        area_r <= area_nxt;
      end
    end
  end

endmodule

// File: rtl/ctbc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbc_queue
// Two-entry queue between the front and back sections.
// ----------------------------------------------------------------------------
module ctbc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ctbc_pkg::ctbc_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output ctbc_pkg::ctbc_item_t head_item
);
  import ctbc_pkg::*;

  ctbc_item_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/ctbc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbc_divider
// Restoring divider, one quotient bit per cycle for both centroid axes.
// ----------------------------------------------------------------------------
module ctbc_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctbc_pkg::ctbc_div_req_t req,
  output ctbc_pkg::ctbc_div_rsp_t rsp
);
  import ctbc_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(XSUM_W - 1);
  localparam logic [DIV_CNT_W-1:0] SAT_STEPS = DIV_CNT_W'(XSUM_W - CENT_W);

  logic [WSUM_W-1:0]    div_r;
  logic [WSUM_W-1:0]    xrem_r, yrem_r, xrem_nxt, yrem_nxt;
  logic [XSUM_W-1:0]    xq_r, yq_r;
  logic                 xsat_r, ysat_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [WSUM_W:0]      xtrial, ytrial;
  logic                 xbit, ybit;

  always_comb begin
    xtrial = {xrem_r, xq_r[XSUM_W-1]};
    ytrial = {yrem_r, yq_r[XSUM_W-1]};
    xbit   = (xtrial >= {1'b0, div_r});
    ybit   = (ytrial >= {1'b0, div_r});
    xrem_nxt = xbit ? WSUM_W'(xtrial - {1'b0, div_r}) : xtrial[WSUM_W-1:0];
    yrem_nxt = ybit ? WSUM_W'(ytrial - {1'b0, div_r}) : ytrial[WSUM_W-1:0];
  end

  assign rsp.busy = busy_r;
  assign rsp.cx   = xsat_r ? '1 : xq_r[CENT_W-1:0];
  assign rsp.cy   = ysat_r ? '1 : yq_r[CENT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r  <= req.wsum;
      xrem_r <= '0;
      yrem_r <= '0;
      xq_r   <= req.xsum;
      yq_r   <= req.ysum;
      xsat_r <= 1'b0;
      ysat_r <= 1'b0;
    end else if (busy_r) begin
      xrem_r <= xrem_nxt;
      yrem_r <= yrem_nxt;
      xq_r   <= {xq_r[XSUM_W-2:0], xbit};
      yq_r   <= {yq_r[XSUM_W-2:0], ybit};
      // A quotient bit above the centroid field forces saturation
      if (xbit && (cnt_r < SAT_STEPS)) begin
        xsat_r <= 1'b1;
      end
      if (ybit && (cnt_r < SAT_STEPS)) begin
        ysat_r <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/ctbc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbc_back
// Drains the queue, runs the frame-end division and holds the output beat.
// ----------------------------------------------------------------------------
module ctbc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    head_valid,
  input  ctbc_pkg::ctbc_item_t    head_item,
  output logic                    pop,
  output ctbc_pkg::ctbc_div_req_t div_req,
  input  ctbc_pkg::ctbc_div_rsp_t div_rsp,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ctbc_pkg::PIX_W-1:0]  out_red,
  output logic [ctbc_pkg::PIX_W-1:0]  out_green,
  output logic [ctbc_pkg::PIX_W-1:0]  out_blue,
  output logic                    out_done,
  output logic [ctbc_pkg::CENT_W-1:0] out_cx,
  output logic [ctbc_pkg::CENT_W-1:0] out_cy,
  output logic [ctbc_pkg::AREA_W-1:0] out_area,
  output logic                    out_empty
);
  import ctbc_pkg::*;

  ctbc_bk_state_t    state_r, state_nxt;
  ctbc_item_t        work_r;
  logic              out_valid_r;
  logic              out_free;
  logic              load;
  logic              capture;
  logic [PIX_W-1:0]  ld_red, ld_green, ld_blue;
  logic              ld_done, ld_empty;
  logic [CENT_W-1:0] ld_cx, ld_cy;
  logic [AREA_W-1:0] ld_area;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    pop           = 1'b0;
    load          = 1'b0;
    capture       = 1'b0;
    div_req.start = 1'b0;
    div_req.xsum  = head_item.xsum;
    div_req.ysum  = head_item.ysum;
    div_req.wsum  = head_item.wsum;
    ld_red        = head_item.red;
    ld_green      = head_item.green;
    ld_blue       = head_item.blue;
    ld_done       = head_item.last;
    ld_cx         = '0;
    ld_cy         = '0;
    ld_area       = head_item.last ? head_item.area : '0;
    ld_empty      = head_item.last;
    case (state_r)
      BK_IDLE: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          if (head_item.last && (head_item.wsum != '0)) begin
            div_req.start = 1'b1;
            capture       = 1'b1;
            state_nxt     = BK_DIV;
          end else begin
            load = 1'b1;
          end
        end
      end
      BK_DIV: begin
        ld_red   = work_r.red;
        ld_green = work_r.green;
        ld_blue  = work_r.blue;
        ld_done  = 1'b1;
        ld_cx    = div_rsp.cx;
        ld_cy    = div_rsp.cy;
        ld_area  = work_r.area;
        ld_empty = 1'b0;
        if (!div_rsp.busy && out_free) begin
          load      = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      work_r <= head_item;
    end
    if (load) begin
      out_red   <= ld_red;
      out_green <= ld_green;
      out_blue  <= ld_blue;
      out_done  <= ld_done;
      out_cx    <= ld_cx;
      out_cy    <= ld_cy;
      out_area  <= ld_area;
      out_empty <= ld_empty;
    end
  end

endmodule

// File: rtl/color_threshold_blob_centroid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_threshold_blob_centroid_core
// RGB color threshold with red-weighted blob centroid per frame.
// ----------------------------------------------------------------------------
// Feed one RGB pixel per beat on the in_ channel in raster order, with
// in_tlast on the final pixel of the frame. Every pixel yields one out_ beat:
// the masked pixel (black when any channel is outside its range). The beat
// for the final pixel carries out_tlast high plus the centroid, the area and
// out_tuser high when the red weight of the frame was zero.
// A pixel beat passes through the queue and the output register; the frame-end
// beat also waits for the 38-step restoring divider (one quotient
// bit per cycle, both axes side by side).
// Throughput: one pixel per cycle within a frame while out_tready is high. A two-beat queue parts the
// thresholding front from the back end, so the front keeps accepting while
// the divider runs until the queue fills.
// A stalled out_tready holds the output register; the queue then fills and
// in_tready drops. Reset (rst_n low, synchronous) loads the default ranges
// and width 640 and clears position, totals, queue and the output valid.
// Registers on the APB port at byte offset 4*i: red_min, red_max,
// green_min, green_max, blue_min, blue_max, frame_width. Write only when idle.
// ----------------------------------------------------------------------------
module color_threshold_blob_centroid_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // [7:0] red, [15:8] green, [23:16] blue
  input  logic        in_tlast,     // frame_last
  // Result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,    // [7:0] out_red, [15:8] out_green,
                                    // [23:16] out_blue, [33:24] centroid_x,
                                    // [43:34] centroid_y, [64:44] blob_area,
                                    // [71:65] zero
  output logic        out_tlast,    // frame_done
  output logic        out_tuser,    // blob_empty
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ctbc_pkg::*;

  ctbc_cfg_t     cfg_r;
  ctbc_reg_t     reg_idx;
  logic          cfg_wr;
  logic          in_accept;
  ctbc_item_t    front_item;
  logic          q_full, q_head_valid, q_pop;
  ctbc_item_t    q_head;
  ctbc_div_req_t div_req;
  ctbc_div_rsp_t div_rsp;
  logic [PIX_W-1:0]  o_red, o_green, o_blue;
  logic [CENT_W-1:0] o_cx, o_cy;
  logic [AREA_W-1:0] o_area;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign reg_idx    = ctbc_reg_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red.lo      <= RST_RED_MIN;
      cfg_r.red.hi      <= RST_RED_MAX;
      cfg_r.green.lo    <= RST_GREEN_MIN;
      cfg_r.green.hi    <= RST_GREEN_MAX;
      cfg_r.blue.lo     <= RST_BLUE_MIN;
      cfg_r.blue.hi     <= RST_BLUE_MAX;
      cfg_r.frame_width <= RST_FRAME_W;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RED_MIN:   cfg_r.red.lo      <= cfg_pwdata[PIX_W-1:0];
        REG_RED_MAX:   cfg_r.red.hi      <= cfg_pwdata[PIX_W-1:0];
        REG_GREEN_MIN: cfg_r.green.lo    <= cfg_pwdata[PIX_W-1:0];
        REG_GREEN_MAX: cfg_r.green.hi    <= cfg_pwdata[PIX_W-1:0];
        REG_BLUE_MIN:  cfg_r.blue.lo     <= cfg_pwdata[PIX_W-1:0];
        REG_BLUE_MAX:  cfg_r.blue.hi     <= cfg_pwdata[PIX_W-1:0];
        REG_FRAME_W:   cfg_r.frame_width <= cfg_pwdata[FW_W-1:0];
        default:       cfg_r             <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RED_MIN:   cfg_prdata = 32'(cfg_r.red.lo);
      REG_RED_MAX:   cfg_prdata = 32'(cfg_r.red.hi);
      REG_GREEN_MIN: cfg_prdata = 32'(cfg_r.green.lo);
      REG_GREEN_MAX: cfg_prdata = 32'(cfg_r.green.hi);
      REG_BLUE_MIN:  cfg_prdata = 32'(cfg_r.blue.lo);
      REG_BLUE_MAX:  cfg_prdata = 32'(cfg_r.blue.hi);
      REG_FRAME_W:   cfg_prdata = 32'(cfg_r.frame_width);
      default:       cfg_prdata = '0;
    endcase
  end

  // Front: accept while the queue has room
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  ctbc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (in_accept),
    .red    (in_tdata[7:0]),
    .green  (in_tdata[15:8]),
    .blue   (in_tdata[23:16]),
    .last   (in_tlast),
    .item   (front_item)
  );

  ctbc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head)
  );

  ctbc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ctbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_item  (q_head),
    .pop        (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_red    (o_red),
    .out_green  (o_green),
    .out_blue   (o_blue),
    .out_done   (out_tlast),
    .out_cx     (o_cx),
    .out_cy     (o_cy),
    .out_area   (o_area),
    .out_empty  (out_tuser)
  );

  assign out_tdata = {7'd0, o_area, o_cy, o_cx, o_blue, o_green, o_red};

endmodule
